// ===== sv/rtf_pkg.sv =====
// Package for the throttle failsafe curve block: constants, codes and control structs.
`default_nettype none
package rtf_pkg;

  // Frame header bytes
  localparam logic [7:0] HdrA     = 8'h10;
  localparam logic [7:0] HdrB     = 8'h47;
  localparam logic [7:0] HdrTrail = 8'hFF;

  // Speed code landmarks
  localparam logic [7:0] DeadHigh = 8'd134;
  localparam logic [7:0] SpeedTop = 8'd254;
  localparam logic [7:0] Neutral  = 8'd127;

  // Register reset values
  localparam logic [7:0] MissLimitRst = 8'd100;
  localparam logic [7:0] RevThrRst    = 8'd34;

  // Pulse widths in us
  localparam int unsigned PulseW = 11;
  localparam logic [PulseW-1:0] PulseMin = 11'd1000;
  localparam logic [PulseW-1:0] PulseMid = 11'd1500;
  localparam logic [PulseW-1:0] PulseMax = 11'd2000;

  // Curve datapath: d is at most 495 on the cubic branch, cube below 2^27
  localparam int unsigned DW      = 9;
  localparam int unsigned MulAW   = 27;
  localparam int unsigned MulBW   = 28;
  localparam int unsigned ProdW   = MulAW + MulBW;
  // floor(cube / 250000) == (cube * Recip) >> RecipShift for every cube < 2^27
  localparam logic [MulBW-1:0] Recip = 28'd140737489;
  localparam int unsigned RecipShift = 45;

  // Configuration register indexes
  localparam logic CfgMissLimit = 1'b0;
  localparam logic CfgRevThr    = 1'b1;

  // Operand select of the shared multiplier
  typedef enum logic [1:0] {
    MUL_SQ,  // d * d
    MUL_CU,  // d^2 * d
    MUL_RC   // cube * reciprocal of 250000
  } mul_sel_e;

  typedef struct packed {
    logic     accept;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic curve;  // speed held after this transaction needs the cubic curve
  } status_t;

endpackage
`default_nettype wire

// ===== sv/rtf_ctrl.sv =====
// Sequencer for the throttle failsafe curve block: handshakes and multiplier passes.
`default_nettype none
module rtf_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire rtf_pkg::status_t status_i,
  output rtf_pkg::cmd_t       cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_CU   = 3'd2;
  localparam logic [2:0] S_RC   = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // Output register can take a new result when empty or being drained
  assign out_free = !out_valid_q || out_ready_i;

  // Next state and commands
  always_comb begin
    state_d          = state_q;
    in_ready_o       = 1'b0;
    cmd_o.accept     = 1'b0;
    cmd_o.mul_en     = 1'b0;
    cmd_o.mul_sel    = rtf_pkg::MUL_SQ;
    cmd_o.out_load   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = status_i.curve ? S_SQ : S_FIN;
        end
      end
      S_SQ: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = rtf_pkg::MUL_SQ;
        state_d       = S_CU;
      end
      S_CU: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = rtf_pkg::MUL_CU;
        state_d       = S_RC;
      end
      S_RC: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = rtf_pkg::MUL_RC;
        state_d       = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid flag
  always_comb begin
    priority if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // Checks
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != S_IDLE))
    else $error("accepted transaction did not start work");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_o)
    else $error("loaded result not presented");

  a_fin_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_free) |=> (state_q == S_IDLE))
    else $error("finished result not handed to the output register");

endmodule
`default_nettype wire

// ===== sv/rtf_datapath.sv =====
// Datapath for the throttle failsafe curve block: config, failsafe state, cube and pulse.
`default_nettype none
module rtf_datapath (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  input  wire logic             cfg_index_i,
  input  wire logic [7:0]       cfg_data_i,
  input  wire logic             func_i,
  input  wire logic [7:0]       header_a_i,
  input  wire logic [7:0]       speed_code_i,
  input  wire logic [7:0]       header_b_i,
  input  wire logic [7:0]       trailer_i,
  input  wire rtf_pkg::cmd_t    cmd_i,
  output rtf_pkg::status_t      status_o,
  output logic [rtf_pkg::PulseW-1:0] pulse_us_o,
  output logic                  frame_ok_o,
  output logic                  failsafe_o,
  output logic [7:0]            speed_now_o
);

  localparam logic [1:0] CLS_MIN  = 2'd0;
  localparam logic [1:0] CLS_MID  = 2'd1;
  localparam logic [1:0] CLS_CUBE = 2'd2;
  localparam logic [1:0] CLS_MAX  = 2'd3;

  logic [7:0] miss_limit_q, rev_thr_q;
  logic [7:0] miss_q, miss_d;
  logic [7:0] held_q, held_d;
  logic       ok, trip;
  logic [8:0] miss_next;
  logic [1:0] cls_d, cls_q;
  logic [7:0] x;
  logic [11:0] x25;
  logic [24:0] x25r;
  logic [rtf_pkg::DW-1:0] d_d, d_q;
  logic       ok_q, fs_q;
  logic [rtf_pkg::MulAW-1:0] mul_a;
  logic [rtf_pkg::MulBW-1:0] mul_b;
  logic [rtf_pkg::ProdW-1:0] mul_p, prod_q;
  logic [rtf_pkg::PulseW-1:0] pulse_d, pulse_q;
  logic       frame_ok_q, failsafe_q;
  logic [7:0] speed_now_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      miss_limit_q <= rtf_pkg::MissLimitRst;
      rev_thr_q    <= rtf_pkg::RevThrRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rtf_pkg::CfgMissLimit: miss_limit_q <= cfg_data_i;
        rtf_pkg::CfgRevThr:    rev_thr_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Frame check and miss counting
  assign ok = func_i && (header_a_i == rtf_pkg::HdrA) && (header_b_i == rtf_pkg::HdrB)
              && (trailer_i == rtf_pkg::HdrTrail);
  assign miss_next = {1'b0, miss_q} + 9'd1;
  assign trip      = !ok && (miss_next > {1'b0, miss_limit_q});

  always_comb begin
    priority if (ok) begin
      held_d = speed_code_i;
      miss_d = '0;
    end else if (trip) begin
      held_d = rtf_pkg::Neutral;
      miss_d = '0;
    end else begin
      held_d = held_q;
      miss_d = miss_next[7:0];
    end
  end

  // Pulse region of the new held speed
  always_comb begin
    priority if (held_d < rev_thr_q) begin
      cls_d = CLS_MIN;
    end else if (held_d <= rtf_pkg::DeadHigh) begin
      cls_d = CLS_MID;
    end else if (held_d >= rtf_pkg::SpeedTop) begin
      cls_d = CLS_MAX;
    end else begin
      cls_d = CLS_CUBE;
    end
  end

  // d = floor((s - 134) * 25 / 6); the /6 is a reciprocal multiply, exact below 3025
  assign x    = held_d - rtf_pkg::DeadHigh;
  assign x25  = {5'b0, x[6:0]} * 12'd25;
  assign x25r = {13'b0, x25} * 25'd10923;
  assign d_d  = x25r[24:16];

  assign status_o.curve = (cls_d == CLS_CUBE);

  // State and per-transaction registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      miss_q <= '0;
      held_q <= rtf_pkg::Neutral;
      cls_q  <= CLS_MID;
      d_q    <= '0;
    end else if (cmd_i.accept) begin
      miss_q <= miss_d;
      held_q <= held_d;
      cls_q  <= cls_d;
      d_q    <= d_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ok_q <= ok;
      fs_q <= trip;
    end
  end

  // Shared multiplier: d^2, d^3, then d^3 / 250000
  always_comb begin
    unique case (cmd_i.mul_sel)
      rtf_pkg::MUL_SQ: begin
        mul_a = rtf_pkg::MulAW'(d_q);
        mul_b = rtf_pkg::MulBW'(d_q);
      end
      rtf_pkg::MUL_CU: begin
        mul_a = rtf_pkg::MulAW'(prod_q[17:0]);
        mul_b = rtf_pkg::MulBW'(d_q);
      end
      rtf_pkg::MUL_RC: begin
        mul_a = prod_q[rtf_pkg::MulAW-1:0];
        mul_b = rtf_pkg::Recip;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = rtf_pkg::ProdW'(mul_a) * rtf_pkg::ProdW'(mul_b);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= mul_p;
    end
  end

  // Pulse width; the cubic branch stays below 2000 since d is at most 495
  always_comb begin
    unique case (cls_q)
      CLS_MIN:  pulse_d = rtf_pkg::PulseMin;
      CLS_MID:  pulse_d = rtf_pkg::PulseMid;
      CLS_MAX:  pulse_d = rtf_pkg::PulseMax;
      CLS_CUBE: pulse_d = rtf_pkg::PulseMid
                          + rtf_pkg::PulseW'(prod_q[rtf_pkg::ProdW-1:rtf_pkg::RecipShift]);
      default:  pulse_d = rtf_pkg::PulseMid;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      pulse_q     <= pulse_d;
      frame_ok_q  <= ok_q;
      failsafe_q  <= fs_q;
      speed_now_q <= held_q;
    end
  end

  assign pulse_us_o  = pulse_q;
  assign frame_ok_o  = frame_ok_q;
  assign failsafe_o  = failsafe_q;
  assign speed_now_o = speed_now_q;

  // Checks
  a_cube_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cls_q == CLS_CUBE) |-> (d_q < 9'd500))
    else $error("cubic branch with offset out of range");

  a_pulse_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> (pulse_q >= rtf_pkg::PulseMin && pulse_q <= rtf_pkg::PulseMax))
    else $error("pulse width out of range");

  a_trip_neutral: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept && trip) |=> (held_q == rtf_pkg::Neutral && miss_q == '0))
    else $error("failsafe did not return to neutral");

endmodule
`default_nettype wire

// ===== sv/rc_throttle_failsafe_curve.sv =====
// Top level of the RC receive failsafe with cubic throttle curve.
// Each input transaction is one receive window; the block checks the frame header, counts
// missed windows, drops to neutral speed once the count passes miss_limit, and returns one
// result with the ESC pulse width for the held speed. A window whose held speed lands in the
// reverse, deadzone or full-throttle region goes straight from acceptance to its last step,
// which loads the output register once it is free; the input is ready again after that load.
// One on the cubic part of the curve first makes three passes through a single shared
// multiplier (d*d, d^2*d, and a reciprocal multiply for the divide by 250000). The next
// window is accepted once the result is in the output register, even if it has not been
// taken yet; it then waits in its last step until the register drains. Configuration
// writes are always accepted.
`default_nettype none
module rc_throttle_failsafe_curve (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        func_i,
  input  wire logic [7:0]  header_a_i,
  input  wire logic [7:0]  speed_code_i,
  input  wire logic [7:0]  header_b_i,
  input  wire logic [7:0]  trailer_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [10:0]      pulse_us_o,
  output logic             frame_ok_o,
  output logic             failsafe_o,
  output logic [7:0]       speed_now_o
);

  rtf_pkg::cmd_t    cmd;
  rtf_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  rtf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rtf_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .func_i       (func_i),
    .header_a_i   (header_a_i),
    .speed_code_i (speed_code_i),
    .header_b_i   (header_b_i),
    .trailer_i    (trailer_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .pulse_us_o   (pulse_us_o),
    .frame_ok_o   (frame_ok_o),
    .failsafe_o   (failsafe_o),
    .speed_now_o  (speed_now_o)
  );

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Testbench for rc_throttle_failsafe_curve: directed windows, then randomized phases.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT    = 1_000_000;
  localparam int unsigned CUBE_DIV       = 250_000;
  localparam int          RAND_PER_PHASE = 160;
  localparam int          DRAIN_CYCLES   = 16;
  localparam int          NUM_DIR        = 19;
  localparam int          NUM_PHASES     = 9;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_e;

  typedef struct packed {
    logic [10:0] pulse_us;
    logic        frame_ok;
    logic        failsafe;
    logic [7:0]  speed_now;
  } window_res_t;

  typedef struct packed {
    logic        func;
    logic [7:0]  hdr_a;
    logic [7:0]  speed_code;
    logic [7:0]  hdr_b;
    logic [7:0]  trail;
    logic        typed;  // res holds a hand-written expectation
    window_res_t res;
  } window_row_t;

  typedef struct packed {
    logic [7:0] miss_limit;
    logic [7:0] rev_thresh;
    idle_e      idle;
  } phase_t;

  localparam window_res_t NO_RES = '0;

  // Clock, reset and DUT ports
  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        func;
  logic [7:0]  hdr_a;
  logic [7:0]  speed_code;
  logic [7:0]  hdr_b;
  logic [7:0]  trailer;
  logic        out_valid;
  logic        out_ready;
  logic [10:0] pulse_us;
  logic        frame_ok;
  logic        failsafe;
  logic [7:0]  speed_now;

  // Predictor copy of configuration and state
  logic [7:0]  miss_limit_q;
  logic [7:0]  rev_thresh_q;
  logic [7:0]  missed_q;
  logic [7:0]  held_speed_q;

  window_res_t pulse_q [$];
  window_res_t head_res;
  int          err_cnt = 0;
  int          send_pct = 0;
  int          stall_pct = 0;
  int unsigned cycle_cnt = 0;

  // Directed windows, run with the reset configuration
  window_row_t dir_rows [NUM_DIR] = '{
    '{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
      '{rtf_pkg::PulseMid, 1'b0, 1'b0, rtf_pkg::Neutral}},
    '{1'b1, rtf_pkg::HdrA, 8'd255, rtf_pkg::HdrB, rtf_pkg::HdrTrail, 1'b1,
      '{rtf_pkg::PulseMax, 1'b1, 1'b0, 8'd255}},
    '{1'b1, rtf_pkg::HdrA, 8'd0, rtf_pkg::HdrB, rtf_pkg::HdrTrail, 1'b1,
      '{rtf_pkg::PulseMin, 1'b1, 1'b0, 8'd0}},
    '{1'b1, rtf_pkg::HdrA, rtf_pkg::DeadHigh, rtf_pkg::HdrB, rtf_pkg::HdrTrail, 1'b1,
      '{rtf_pkg::PulseMid, 1'b1, 1'b0, rtf_pkg::DeadHigh}},
    '{1'b1, rtf_pkg::HdrA, 8'd135, rtf_pkg::HdrB, rtf_pkg::HdrTrail, 1'b0, NO_RES},
    '{1'b1, rtf_pkg::HdrA, rtf_pkg::RevThrRst, rtf_pkg::HdrB, rtf_pkg::HdrTrail, 1'b1,
      '{rtf_pkg::PulseMid, 1'b1, 1'b0, rtf_pkg::RevThrRst}},
    '{1'b1, rtf_pkg::HdrA, 8'd33, rtf_pkg::HdrB, rtf_pkg::HdrTrail, 1'b1,
      '{rtf_pkg::PulseMin, 1'b1, 1'b0, 8'd33}},
    '{1'b1, rtf_pkg::HdrA, 8'd200, rtf_pkg::HdrB, rtf_pkg::HdrTrail, 1'b0, NO_RES},
    '{1'b1, rtf_pkg::HdrA, rtf_pkg::SpeedTop, rtf_pkg::HdrB, rtf_pkg::HdrTrail, 1'b0, NO_RES},
    // timeout that still carries good header bytes
    '{1'b0, rtf_pkg::HdrA, 8'h00, rtf_pkg::HdrB, rtf_pkg::HdrTrail, 1'b0, NO_RES},
    '{1'b1, 8'h11, 8'd10, rtf_pkg::HdrB, rtf_pkg::HdrTrail, 1'b0, NO_RES},
    '{1'b1, rtf_pkg::HdrA, 8'd10, 8'h46, rtf_pkg::HdrTrail, 1'b0, NO_RES},
    '{1'b1, rtf_pkg::HdrA, 8'd10, rtf_pkg::HdrB, 8'hFE, 1'b0, NO_RES},
    '{1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, NO_RES},
    '{1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NO_RES},
    '{1'b1, rtf_pkg::HdrA, 8'd128, rtf_pkg::HdrB, rtf_pkg::HdrTrail, 1'b1,
      '{rtf_pkg::PulseMid, 1'b1, 1'b0, 8'd128}},
    '{1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, NO_RES},
    '{1'b1, rtf_pkg::HdrA, 8'd170, rtf_pkg::HdrB, rtf_pkg::HdrTrail, 1'b0, NO_RES},
    '{1'b1, rtf_pkg::HdrA, 8'd100, rtf_pkg::HdrB, rtf_pkg::HdrTrail, 1'b1,
      '{rtf_pkg::PulseMid, 1'b1, 1'b0, 8'd100}}
  };

  // Register settings and idling per random phase
  phase_t phases [NUM_PHASES] = '{
    '{rtf_pkg::MissLimitRst, rtf_pkg::RevThrRst, IDLE_NONE},
    '{8'd0,   8'd0,   IDLE_SEND},
    '{8'd255, 8'd134, IDLE_RECV},
    '{8'd1,   8'd255, IDLE_BOTH},
    '{8'd3,   8'd200, IDLE_NONE},
    '{8'd255, 8'd0,   IDLE_BOTH},
    '{8'd7,   8'd135, IDLE_RECV},
    '{8'd2,   8'd1,   IDLE_SEND},
    '{8'd0,   8'd255, IDLE_BOTH}
  };

  rc_throttle_failsafe_curve u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .func_i       (func),
    .header_a_i   (hdr_a),
    .speed_code_i (speed_code),
    .header_b_i   (hdr_b),
    .trailer_i    (trailer),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .pulse_us_o   (pulse_us),
    .frame_ok_o   (frame_ok),
    .failsafe_o   (failsafe),
    .speed_now_o  (speed_now)
  );

  // Pulse width for a held speed code
  function automatic logic [10:0] throttle_pulse(logic [7:0] s);
    int unsigned sv;
    int unsigned d;
    int unsigned cube;
    int unsigned p;
    sv = s;
    if (s < rev_thresh_q) return rtf_pkg::PulseMin;
    if (s <= rtf_pkg::DeadHigh) return rtf_pkg::PulseMid;
    d = ((sv - rtf_pkg::DeadHigh) * (rtf_pkg::PulseMax - rtf_pkg::PulseMid))
        / (rtf_pkg::SpeedTop - rtf_pkg::DeadHigh);
    cube = d * d * d;  // d <= 504, fits 32 bits
    p = rtf_pkg::PulseMid + cube / CUBE_DIV;
    if (p > rtf_pkg::PulseMax) p = rtf_pkg::PulseMax;
    return p[10:0];
  endfunction

  // Advance the miss counter and held speed for one window
  function automatic window_res_t receive_window(logic f, logic [7:0] a, logic [7:0] sc,
                                                 logic [7:0] b, logic [7:0] t);
    window_res_t r;
    logic        good;
    int unsigned next_miss;
    good = f && a == rtf_pkg::HdrA && b == rtf_pkg::HdrB && t == rtf_pkg::HdrTrail;
    r.failsafe = 1'b0;
    if (good) begin
      missed_q = '0;
      held_speed_q = sc;
    end else begin
      next_miss = missed_q + 1;  // compared wider than eight bits, so a limit of 255 still trips
      if (next_miss > miss_limit_q) begin
        missed_q = '0;
        held_speed_q = rtf_pkg::Neutral;
        r.failsafe = 1'b1;
      end else begin
        missed_q = next_miss[7:0];
      end
    end
    r.pulse_us = throttle_pulse(held_speed_q);
    r.frame_ok = good;
    r.speed_now = held_speed_q;
    return r;
  endfunction

  function automatic void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  // One input transaction; valid is left high for a back-to-back window
  task automatic send_window(window_row_t w);
    window_res_t want;
    @(negedge clk_i);
    in_valid   <= 1'b1;
    func       <= w.func;
    hdr_a      <= w.hdr_a;
    speed_code <= w.speed_code;
    hdr_b      <= w.hdr_b;
    trailer    <= w.trail;
    do @(posedge clk_i); while (!in_ready);
    want = receive_window(w.func, w.hdr_a, w.speed_code, w.hdr_b, w.trail);
    if (w.typed) want = w.res;
    pulse_q.push_back(want);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic hold_until_drained();
    @(negedge clk_i) in_valid <= 1'b0;
    while (pulse_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [7:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    if (idx == rtf_pkg::CfgMissLimit) miss_limit_q = data;
    else rev_thresh_q = data;
    @(negedge clk_i) cfg_valid <= 1'b0;
  endtask

  // Mostly good frames; occasional miss bursts long enough to reach failsafe
  task automatic run_random(int n);
    int          burst_left;
    int unsigned pick;
    window_row_t w;
    burst_left = 0;
    for (int i = 0; i < n || burst_left > 0; i++) begin
      if ($urandom_range(0, 99) == 0) hold_until_drained();
      w = '0;
      w.func = 1'b1;
      w.hdr_a = rtf_pkg::HdrA;
      w.hdr_b = rtf_pkg::HdrB;
      w.trail = rtf_pkg::HdrTrail;
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 7))
          0: w.speed_code = 8'd0;
          1: w.speed_code = 8'd255;
          2: w.speed_code = rtf_pkg::DeadHigh;
          3: w.speed_code = rtf_pkg::DeadHigh + 8'd1;
          4: w.speed_code = rtf_pkg::SpeedTop;
          5: w.speed_code = rev_thresh_q;
          6: w.speed_code = rev_thresh_q - 8'd1;
          default: w.speed_code = rtf_pkg::Neutral;
        endcase
      end else begin
        w.speed_code = 8'($urandom);
      end
      pick = $urandom_range(0, 99);
      if (burst_left == 0 && pick < 3)
        burst_left = miss_limit_q + 1 + $urandom_range(0, 2);
      if (burst_left > 0) begin
        burst_left--;
        pick = $urandom_range(62, 99);
      end
      if (pick >= 62 && pick < 82) begin
        // timeout, sometimes with good header bytes left on the bus
        w.func = 1'b0;
        if ($urandom_range(0, 1)) begin
          w.hdr_a = 8'($urandom);
          w.hdr_b = 8'($urandom);
          w.trail = 8'($urandom);
        end
      end else if (pick >= 82) begin
        case ($urandom_range(0, 3))
          0: w.hdr_a = rtf_pkg::HdrA ^ 8'($urandom_range(1, 255));
          1: w.hdr_b = rtf_pkg::HdrB ^ 8'($urandom_range(1, 255));
          2: w.trail = rtf_pkg::HdrTrail ^ 8'($urandom_range(1, 255));
          default: begin
            w.hdr_a = 8'($urandom);
            w.hdr_b = 8'($urandom);
            w.trail = 8'($urandom);
          end
        endcase
      end
      send_window(w);
      while (send_pct > 0 && $urandom_range(0, 99) < send_pct)
        @(negedge clk_i) in_valid <= 1'b0;
    end
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Receiver backpressure
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready <= !(stall_pct > 0 && $urandom_range(0, 99) < stall_pct);
    end
  end

  // Compare each result transaction against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (pulse_q.size() == 0) begin
        err_cnt++;
        $display("%0t: result with none expected, actual pulse %0d speed %0d",
                 $time, pulse_us, speed_now);
      end else begin
        head_res = pulse_q.pop_front();
        check_field("pulse_us", head_res.pulse_us, pulse_us);
        check_field("frame_ok", head_res.frame_ok, frame_ok);
        check_field("failsafe", head_res.failsafe, failsafe);
        check_field("speed_now", head_res.speed_now, speed_now);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Main sequence
  initial begin
    rst_ni       = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = rtf_pkg::CfgMissLimit;
    cfg_data     = '0;
    in_valid     = 1'b0;
    func         = 1'b0;
    hdr_a        = '0;
    speed_code   = '0;
    hdr_b        = '0;
    trailer      = '0;
    miss_limit_q = rtf_pkg::MissLimitRst;
    rev_thresh_q = rtf_pkg::RevThrRst;
    missed_q     = '0;
    held_speed_q = rtf_pkg::Neutral;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_window(dir_rows[i]);

    foreach (phases[p]) begin
      hold_until_drained();
      write_reg(rtf_pkg::CfgMissLimit, phases[p].miss_limit);
      write_reg(rtf_pkg::CfgRevThr, phases[p].rev_thresh);
      send_pct  = (phases[p].idle == IDLE_SEND) ? 77 : (phases[p].idle == IDLE_BOTH) ? 28 : 0;
      stall_pct = (phases[p].idle == IDLE_RECV) ? 77 : (phases[p].idle == IDLE_BOTH) ? 28 : 0;
      run_random(RAND_PER_PHASE);
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && pulse_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
